FILE: design/asm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload structs, codes and state type for the sine tone mixer.
package asm_pkg;

    // Sizing
    localparam int MAX_TONES        = 8;
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;

    // Field widths
    localparam int FREQ_W   = 21;
    localparam int AMP_W    = 16;
    localparam int RATE_W   = 18;
    localparam int SAMPLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 19;

    // Derived widths
    localparam int TONE_IDX_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int TONE_CNT_W = $clog2(MAX_TONES + 1);
    localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W     = 32;
    localparam int SUM_W      = PROD_W + $clog2(MAX_TONES);
    localparam int DEN_W      = RATE_W + 4;
    localparam int DIV_N      = (FREQ_W + PHASE_BITS > SUM_W) ? (FREQ_W + PHASE_BITS) : SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_N + 1);

    // Config port
    localparam int CFG_DATA_W = RATE_W;

    // Constants
    localparam logic [RATE_W-1:0]     RATE_RESET = RATE_W'(48000);
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = '1;
    localparam logic [TONE_CNT_W-1:0] TONE_FULL  = TONE_CNT_W'(MAX_TONES);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_TICK_ALT = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_SAMPLE  = 2'd0,
        STAT_ADDED   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_WAVE_ON     = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_DIV,
        S_TICK_LOOK,
        S_TICK_MUL,
        S_TICK_ACC,
        S_MIX_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        t_status                    status;
    } t_out_item;

    // Tone table controls
    typedef struct packed {
        logic                  wr;
        logic                  adv;
        logic                  clr;
        logic [TONE_IDX_W-1:0] idx;
    } t_tone_ctl;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: design/asm_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module asm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [asm_pkg::DIV_N-1:0] i_num,
    input  logic [asm_pkg::DEN_W-1:0] i_den,
    output asm_pkg::t_div_stat        o_stat,
    output logic [asm_pkg::DIV_N-1:0] o_quot
);
    import asm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_N-1:0]     r_quot;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    // Shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh   = {r_rem, r_num[DIV_N-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = (rem_sh >= {1'b0, r_den});
        n_rem    = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_N-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIV_N-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

FILE: design/asm_sine.sv
`timescale 1ns / 1ps
// Q15 sine lookup: quarter-wave table with quadrant mirroring.
module asm_sine (
    input  logic [asm_pkg::SINE_IDX_W-1:0]    i_idx,
    output logic signed [asm_pkg::SAMPLE_W-1:0] o_sine
);
    import asm_pkg::*;

    localparam int QBITS   = SINE_IDX_W - 2;
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SAMPLE_W-2:0] t_sine_rom [QUARTER+1];

    // Odd Taylor series to 11th order on a quarter wave, Q30, rounded to Q15
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned f;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        longint unsigned s;
        for (int j = 0; j <= QUARTER; j++) begin
            f   = 64'(j) << (30 - QBITS);
            t   = (f * HALF_PI_Q30) >> 30;
            t2  = (t * t) >> 30;
            acc = Q30_ONE - ((t2 * Q30_ONE) >> 30) / 110;
            acc = Q30_ONE - ((t2 * acc) >> 30) / 72;
            acc = Q30_ONE - ((t2 * acc) >> 30) / 42;
            acc = Q30_ONE - ((t2 * acc) >> 30) / 20;
            acc = Q30_ONE - ((t2 * acc) >> 30) / 6;
            s   = (t * acc) >> 30;
            s   = (s + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            rom[j] = (SAMPLE_W-1)'(s);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam logic [QBITS:0] QUARTER_J = (QBITS+1)'(QUARTER);

    logic [1:0]          quad;
    logic [QBITS:0]      j;
    logic [SAMPLE_W-2:0] mag;

    // Mirror odd quadrants, negate the second half turn
    always_comb begin
        quad   = i_idx[SINE_IDX_W-1 -: 2];
        j      = quad[0] ? (QUARTER_J - {1'b0, i_idx[QBITS-1:0]}) : {1'b0, i_idx[QBITS-1:0]};
        mag    = SINE_ROM[j];
        o_sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

FILE: design/asm_tones.sv
`timescale 1ns / 1ps
// Tone table: per-tone phase step, weight and wrapping phase accumulator.
module asm_tones (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  asm_pkg::t_tone_ctl             i_ctl,
    input  logic [asm_pkg::PHASE_BITS-1:0] i_step,
    input  logic [asm_pkg::AMP_W-1:0]      i_weight,
    output logic [asm_pkg::PHASE_BITS-1:0] o_phase,
    output logic [asm_pkg::AMP_W-1:0]      o_weight
);
    import asm_pkg::*;

    logic [PHASE_BITS-1:0] r_step   [MAX_TONES];
    logic [AMP_W-1:0]      r_weight [MAX_TONES];
    logic [PHASE_BITS-1:0] r_phase  [MAX_TONES];

    // Step and weight, written on add only
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_step[i_ctl.idx]   <= i_step;
            r_weight[i_ctl.idx] <= i_weight;
        end
    end

    // Phases: clear all, restart on add, advance on tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int k = 0; k < MAX_TONES; k++) begin
                r_phase[k] <= '0;
            end
        end else if (i_ctl.wr) begin
            r_phase[i_ctl.idx] <= '0;
        end else if (i_ctl.adv) begin
            r_phase[i_ctl.idx] <= r_phase[i_ctl.idx] + r_step[i_ctl.idx];
        end
    end

    assign o_phase  = r_phase[i_ctl.idx];
    assign o_weight = r_weight[i_ctl.idx];

endmodule

FILE: design/additive_sine_tone_mixer.sv
`timescale 1ns / 1ps
// Top level of the additive sine tone mixer: sequencer, mix datapath, output register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Add runs the shared divider, which forms the phase step one bit a cycle.
// Tick steps through each stored tone in lookup, multiply and accumulate states, then,
// if the weight total is nonzero, runs the normalizing divide; clear, full, wave-off and
// empty ticks go straight to the done state. Synchronous reset clears count, weight total
// and all phases.
// A finished result waits in the output register while the next item is accepted;
// the sequencer holds a new result only while that register is still occupied.
module additive_sine_tone_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  asm_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output asm_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  asm_pkg::t_cfg_reg              i_cfg_index,
    input  logic [asm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import asm_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0]          r_rate;
    logic                       r_wave_on;
    logic [TONE_CNT_W-1:0]      r_count;
    logic [TOTAL_W-1:0]         r_total;
    logic [TONE_IDX_W-1:0]      r_k;
    logic [AMP_W-1:0]           r_amp;
    logic signed [SAMPLE_W-1:0] r_sine;
    logic [AMP_W-1:0]           r_wt;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_neg;
    t_out_item                  r_res;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       in_acc;
    logic                       out_free;
    logic                       is_full;
    logic                       last_tone;
    logic                       div_start;
    logic [DIV_N-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    t_div_stat                  div_stat;
    logic [DIV_N-1:0]           div_quot;
    t_tone_ctl                  tone_ctl;
    logic [PHASE_BITS-1:0]      tone_phase;
    logic [AMP_W-1:0]           tone_weight;
    logic signed [SAMPLE_W-1:0] sine_val;
    logic signed [PROD_W:0]     mul_full;
    logic signed [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]           sum_mag;
    logic [TOTAL_W:0]           total_sum;
    logic [TOTAL_W-1:0]         n_total;
    logic [RATE_W-1:0]          rate_eff;
    logic signed [SAMPLE_W-1:0] mix_sample;

    // Units
    asm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    asm_tones u_tones (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tone_ctl),
        .i_step   (div_quot[PHASE_BITS-1:0]),
        .i_weight (r_amp),
        .o_phase  (tone_phase),
        .o_weight (tone_weight)
    );

    asm_sine u_sine (
        .i_idx  (tone_phase[PHASE_BITS-1 -: SINE_IDX_W]),
        .o_sine (sine_val)
    );

    // Handshake and datapath helpers
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        out_free  = !r_out_valid || i_out_ready;
        is_full   = (r_count == TONE_FULL);
        last_tone = ((TONE_CNT_W'(r_k) + TONE_CNT_W'(1)) == r_count);
        mul_full  = r_sine * $signed({1'b0, r_wt});
        sum_new   = r_sum + SUM_W'(r_prod);
        sum_mag   = sum_new[SUM_W-1] ? unsigned'(-sum_new) : unsigned'(sum_new);
        total_sum = {1'b0, r_total} + (TOTAL_W+1)'(r_amp);
        n_total   = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        rate_eff  = (r_rate == '0) ? RATE_W'(1) : r_rate;
    end

    // Saturate the normalized magnitude and restore the sign
    always_comb begin
        if (r_neg) begin
            mix_sample = (div_quot > DIV_N'(32768)) ? SAMPLE_MIN
                                                    : -$signed(div_quot[SAMPLE_W-1:0]);
        end else begin
            mix_sample = (div_quot > DIV_N'(32767)) ? SAMPLE_MAX
                                                    : $signed(div_quot[SAMPLE_W-1:0]);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode) inside
                        MODE_ADD:   n_state = is_full ? S_DONE : S_ADD_DIV;
                        MODE_CLEAR: n_state = S_DONE;
                        MODE_TICK, MODE_TICK_ALT:
                            n_state = (r_wave_on && r_count != '0) ? S_TICK_LOOK : S_DONE;
                    endcase
                end
            end
            S_ADD_DIV:   n_state = div_stat.done ? S_DONE : S_ADD_DIV;
            S_TICK_LOOK: n_state = S_TICK_MUL;
            S_TICK_MUL:  n_state = S_TICK_ACC;
            S_TICK_ACC: begin
                if (!last_tone) begin
                    n_state = S_TICK_LOOK;
                end else begin
                    n_state = (r_total != '0) ? S_MIX_DIV : S_DONE;
                end
            end
            S_MIX_DIV:   n_state = div_stat.done ? S_DONE : S_MIX_DIV;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        div_start    = 1'b0;
        div_num      = {i_in_data.frequency, {PHASE_BITS{1'b0}}};
        div_den      = {rate_eff, 4'b0000};
        tone_ctl.wr  = 1'b0;
        tone_ctl.adv = 1'b0;
        tone_ctl.clr = 1'b0;
        tone_ctl.idx = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.mode) inside
                        MODE_ADD:   div_start = !is_full;
                        MODE_CLEAR: div_start = 1'b0;
                        MODE_TICK, MODE_TICK_ALT: tone_ctl.clr = !r_wave_on;
                    endcase
                end
            end
            S_ADD_DIV: begin
                tone_ctl.idx = TONE_IDX_W'(r_count);
                tone_ctl.wr  = div_stat.done;
            end
            S_TICK_LOOK: tone_ctl.adv = 1'b1;
            S_TICK_ACC: begin
                div_num   = DIV_N'(sum_mag);
                div_den   = DEN_W'(r_total);
                div_start = last_tone && (r_total != '0);
            end
            S_TICK_MUL, S_MIX_DIV, S_DONE: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_wave_on   <= 1'b0;
            r_count     <= '0;
            r_total     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_rate    <= i_cfg_data;
                    CFG_WAVE_ON:     r_wave_on <= i_cfg_data[0];
                endcase
            end
            // Table bookkeeping
            if (r_state == S_IDLE && in_acc) begin
                r_k <= '0;
                if (i_in_data.mode == MODE_CLEAR) begin
                    r_count <= '0;
                    r_total <= '0;
                end
            end else if (r_state == S_ADD_DIV && div_stat.done) begin
                r_count <= r_count + TONE_CNT_W'(1);
                r_total <= n_total;
            end else if (r_state == S_TICK_ACC && !last_tone) begin
                r_k <= r_k + TONE_IDX_W'(1);
            end
            // Output register
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_amp        <= i_in_data.amplitude;
            r_sum        <= '0;
            r_res.sample <= '0;
            unique case (i_in_data.mode) inside
                MODE_ADD:                 r_res.status <= STAT_FULL;
                MODE_CLEAR:               r_res.status <= STAT_CLEARED;
                MODE_TICK, MODE_TICK_ALT: r_res.status <= STAT_SAMPLE;
            endcase
        end
        if (r_state == S_ADD_DIV && div_stat.done) begin
            r_res.status <= STAT_ADDED;
        end
        if (r_state == S_TICK_LOOK) begin
            r_sine <= sine_val;
            r_wt   <= tone_weight;
        end
        if (r_state == S_TICK_MUL) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        if (r_state == S_TICK_ACC) begin
            r_sum <= sum_new;
            r_neg <= sum_new[SUM_W-1];
        end
        if (r_state == S_MIX_DIV && div_stat.done) begin
            r_res.sample <= mix_sample;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Checks
    a_full_add_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode == MODE_ADD && is_full) |=>
            ($stable(r_count) && $stable(r_total)))
        else $error("dropped add changed the tone table");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode == MODE_CLEAR) |=> (r_count == '0 && r_total == '0))
        else $error("clear left tones in the table");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_ADD_DIV || r_state == S_MIX_DIV))
        else $error("divider running outside a divide state");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised without passing the done state");

endmodule
